FILE: sv/ldl_pkg.sv
// ============================================================================
// ldl_pkg - shared types and constants of the indexed doubly linked list unit
// Field widths, request and status codes, sequencer states and the write
// lane enables of the link memory.
// ============================================================================
package ldl_pkg;

    localparam int NODES_DEF = 1024;
    localparam int REQ_W     = 3;
    localparam int LINK_W    = 11;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;

    // link value meaning "no node"
    localparam logic [LINK_W-1:0] NIL = {LINK_W{1'b1}};

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN      = 3'd0,
        REQ_LOAD       = 3'd1,
        REQ_DELETE     = 3'd2,
        REQ_INS_AFTER  = 3'd3,
        REQ_INS_BEFORE = 3'd4,
        REQ_READ       = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // operation held by the sequencer for the item in flight
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_READ,
        OP_DELETE,
        OP_INS_AFTER,
        OP_INS_BEFORE
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_LINK1,
        S_LINK2,
        S_NODE,
        S_DONE
    } state_t;

    // per-lane write enables of the link memory
    typedef struct packed {
        logic nxt;
        logic prv;
    } link_we_t;

endpackage

FILE: sv/ldl_value_mem.sv
// ============================================================================
// ldl_value_mem - node value store
// Single-port synchronous RAM with a registered read; read data holds until
// the next read.
// ============================================================================
module ldl_value_mem #(
    parameter int NODES = ldl_pkg::NODES_DEF
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic                             wr_en,
    input  logic [$clog2(NODES)-1:0]         addr,
    input  logic [ldl_pkg::VALUE_W-1:0]      wr_data,
    output logic [ldl_pkg::VALUE_W-1:0]      rd_data
);
    import ldl_pkg::*;

    logic [VALUE_W-1:0] mem [NODES];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[addr];
        end
    end

endmodule

FILE: sv/ldl_link_mem.sv
// ============================================================================
// ldl_link_mem - node link store
// Single-port synchronous RAM holding the next and previous link of each
// node, with a write enable per link lane and a registered read.
// ============================================================================
module ldl_link_mem #(
    parameter int NODES = ldl_pkg::NODES_DEF
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  ldl_pkg::link_we_t                wr_en,
    input  logic [$clog2(NODES)-1:0]         addr,
    input  logic [ldl_pkg::LINK_W-1:0]       wr_next,
    input  logic [ldl_pkg::LINK_W-1:0]       wr_prev,
    output logic [ldl_pkg::LINK_W-1:0]       rd_next,
    output logic [ldl_pkg::LINK_W-1:0]       rd_prev
);
    import ldl_pkg::*;

    logic [LINK_W-1:0] next_mem [NODES];
    logic [LINK_W-1:0] prev_mem [NODES];

    // lane writes
    always_ff @(posedge aclk) begin
        if (wr_en.nxt) begin
            next_mem[addr] <= wr_next;
        end
        if (wr_en.prv) begin
            prev_mem[addr] <= wr_prev;
        end
    end

    // registered read of both lanes
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_next <= next_mem[addr];
            rd_prev <= prev_mem[addr];
        end
    end

endmodule

FILE: sv/indexed_doubly_linked_list_unit.sv
// ============================================================================
// indexed_doubly_linked_list_unit - array-backed doubly linked list engine
// Sequencer around a value RAM and a link RAM; one result per request.
// ============================================================================
// The unit takes one request at a time and returns exactly one result for it.
// Begin, unknown and rejected (full store or bad index) requests go straight
// to the done step; a load writes the node; a read looks it up; an insert at a
// list end links the old end, then writes the node; a delete looks the node up
// and relinks both neighbors; an insert next to a node looks up the target,
// links both neighbors, then writes the node. The single-port link RAM sets
// the steps: the node lookup and every link update (the neighbor links, then
// the new node) each have a RAM step of their own, and the done step loads the
// result. The next request is accepted while a result still waits on m_ready.
// Stores need no clearing after reset; head and tail reset to -1, allocator 0.
module indexed_doubly_linked_list_unit #(
    parameter int NODES = ldl_pkg::NODES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ldl_pkg::REQ_W-1:0]             s_req_type,
    input  logic signed [ldl_pkg::LINK_W-1:0]     s_node_index,
    input  logic signed [ldl_pkg::VALUE_W-1:0]    s_value,
    input  logic signed [ldl_pkg::LINK_W-1:0]     s_next_link,
    input  logic signed [ldl_pkg::LINK_W-1:0]     s_prev_link,
    input  logic signed [ldl_pkg::LINK_W-1:0]     s_head_link,
    input  logic signed [ldl_pkg::LINK_W-1:0]     s_tail_link,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [ldl_pkg::VALUE_W-1:0]    m_out_value,
    output logic signed [ldl_pkg::LINK_W-1:0]     m_out_index,
    output logic signed [ldl_pkg::LINK_W-1:0]     m_out_next,
    output logic signed [ldl_pkg::LINK_W-1:0]     m_out_prev,
    output logic signed [ldl_pkg::LINK_W-1:0]     m_out_head,
    output logic signed [ldl_pkg::LINK_W-1:0]     m_out_tail,
    output logic [ldl_pkg::STATUS_W-1:0]          m_status
);
    import ldl_pkg::*;

    localparam int AW   = $clog2(NODES);
    localparam int CNTW = $clog2(NODES + 1);
    localparam int CW   = (CNTW > LINK_W) ? CNTW : LINK_W;

    // link value names a node that exists in the store
    function automatic logic idx_ok(input logic [LINK_W-1:0] x);
        return !x[LINK_W-1] && (CW'(x) < CW'(NODES));
    endfunction

    state_t             state_reg, state_next;
    op_t                op_reg;
    status_t            status_reg;
    logic               end_reg;
    logic [LINK_W-1:0]  id_reg;
    logic [VALUE_W-1:0] val_reg;
    logic [AW-1:0]      n_reg;
    logic [LINK_W-1:0]  a_reg;
    logic [LINK_W-1:0]  b_reg;
    logic [LINK_W-1:0]  head_reg;
    logic [LINK_W-1:0]  tail_reg;
    logic [CNTW-1:0]    alloc_reg;
    logic               m_valid_reg;

    op_t                acc_op;
    status_t            acc_status;
    logic               acc_end;
    logic               acc_read;
    logic               full;
    logic               out_load;
    logic [LINK_W-1:0]  n_link;
    logic [AW-1:0]      id_addr;

    logic               v_rd_en, v_wr_en;
    logic [AW-1:0]      v_addr;
    logic [VALUE_W-1:0] v_rd_data;
    logic               l_rd_en;
    link_we_t           l_wr_en;
    logic [AW-1:0]      l_addr;
    logic [LINK_W-1:0]  l_wr_next, l_wr_prev;
    logic [LINK_W-1:0]  l_rd_next, l_rd_prev;

    assign full    = (alloc_reg >= CNTW'(NODES));
    assign n_link  = LINK_W'(n_reg);
    assign id_addr = AW'(id_reg);
    assign m_valid = m_valid_reg;

    // request decode at the accepting edge
    always_comb begin
        acc_op     = OP_NONE;
        acc_status = ST_OK;
        acc_end    = 1'b0;
        acc_read   = 1'b0;
        case (s_req_type)
            REQ_BEGIN: begin
                acc_op = OP_NONE;
            end
            REQ_LOAD: begin
                if (full) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_op = OP_LOAD;
                end
            end
            REQ_DELETE, REQ_READ: begin
                if (!idx_ok(s_node_index)) begin
                    acc_status = ST_RANGE;
                end else begin
                    acc_op   = (s_req_type == REQ_READ) ? OP_READ : OP_DELETE;
                    acc_read = 1'b1;
                end
            end
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
                if (s_node_index != NIL && !idx_ok(s_node_index)) begin
                    acc_status = ST_RANGE;
                end else if (full) begin
                    acc_status = ST_FULL;
                end else begin
                    acc_op   = (s_req_type == REQ_INS_AFTER) ? OP_INS_AFTER
                                                             : OP_INS_BEFORE;
                    acc_end  = (s_node_index == NIL);
                    acc_read = (s_node_index != NIL);
                end
            end
            default: begin
                acc_op = OP_NONE;
            end
        endcase
    end

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    case (acc_op)
                        OP_NONE:             state_next = S_DONE;
                        OP_LOAD:             state_next = S_NODE;
                        OP_READ, OP_DELETE:  state_next = S_LOOKUP;
                        default:             state_next = acc_end ? S_LINK2 : S_LOOKUP;
                    endcase
                end
            end
            S_LOOKUP: begin
                state_next = (op_reg == OP_READ) ? S_DONE : S_LINK1;
            end
            S_LINK1: begin
                state_next = S_LINK2;
            end
            S_LINK2: begin
                state_next = (op_reg == OP_DELETE) ? S_DONE : S_NODE;
            end
            S_NODE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs: handshake and memory port controls
    always_comb begin
        s_ready   = 1'b0;
        v_rd_en   = 1'b0;
        v_wr_en   = 1'b0;
        v_addr    = n_reg;
        l_rd_en   = 1'b0;
        l_wr_en   = '0;
        l_addr    = n_reg;
        l_wr_next = a_reg;
        l_wr_prev = b_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                v_addr  = AW'(s_node_index);
                l_addr  = AW'(s_node_index);
                v_rd_en = s_valid && (acc_op == OP_READ || acc_op == OP_DELETE);
                l_rd_en = s_valid && acc_read;
            end
            S_LINK1: begin
                // delete: next of the previous node; insert: link of the target
                if (op_reg == OP_DELETE) begin
                    l_addr      = AW'(b_reg);
                    l_wr_en.nxt = idx_ok(b_reg);
                    l_wr_next   = a_reg;
                end else if (op_reg == OP_INS_AFTER) begin
                    l_addr      = id_addr;
                    l_wr_en.nxt = 1'b1;
                    l_wr_next   = n_link;
                end else begin
                    l_addr      = id_addr;
                    l_wr_en.prv = 1'b1;
                    l_wr_prev   = n_link;
                end
            end
            S_LINK2: begin
                // link of the far neighbor: back link, or next link for insert before
                if (op_reg == OP_DELETE) begin
                    l_addr      = AW'(a_reg);
                    l_wr_en.prv = idx_ok(a_reg);
                    l_wr_prev   = b_reg;
                end else if (op_reg == OP_INS_AFTER) begin
                    l_addr      = AW'(a_reg);
                    l_wr_en.prv = idx_ok(a_reg);
                    l_wr_prev   = n_link;
                end else begin
                    l_addr      = AW'(b_reg);
                    l_wr_en.nxt = idx_ok(b_reg);
                    l_wr_next   = n_link;
                end
            end
            S_NODE: begin
                v_wr_en = 1'b1;
                l_wr_en = '{nxt: 1'b1, prv: 1'b1};
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control state: sequencer, list ends, allocator, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= NIL;
            tail_reg    <= NIL;
            alloc_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (s_req_type == REQ_BEGIN) begin
                            head_reg  <= s_head_link;
                            tail_reg  <= s_tail_link;
                            alloc_reg <= '0;
                        end
                        if (acc_op == OP_LOAD || acc_op == OP_INS_AFTER ||
                            acc_op == OP_INS_BEFORE) begin
                            alloc_reg <= alloc_reg + CNTW'(1);
                        end
                    end
                end
                S_LINK1: begin
                    if (op_reg == OP_DELETE) begin
                        if (b_reg == NIL) begin
                            head_reg <= a_reg;
                        end
                        if (a_reg == NIL) begin
                            tail_reg <= b_reg;
                        end
                    end
                end
                S_LINK2: begin
                    if (op_reg == OP_INS_AFTER) begin
                        if (a_reg == NIL) begin
                            tail_reg <= n_link;
                        end
                        if (end_reg) begin
                            head_reg <= n_link;
                        end
                    end else if (op_reg == OP_INS_BEFORE) begin
                        if (b_reg == NIL) begin
                            head_reg <= n_link;
                        end
                        if (end_reg) begin
                            tail_reg <= n_link;
                        end
                    end
                end
                default: begin
                    head_reg <= head_reg;
                end
            endcase
        end
    end

    // item payload and link working registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_reg     <= acc_op;
                    status_reg <= acc_status;
                    end_reg    <= acc_end;
                    id_reg     <= s_node_index;
                    val_reg    <= s_value;
                    n_reg      <= alloc_reg[AW-1:0];
                    // insert at an end: the old end becomes the neighbor
                    if (acc_end && acc_op == OP_INS_AFTER) begin
                        a_reg <= head_reg;
                        b_reg <= NIL;
                    end else if (acc_end) begin
                        a_reg <= NIL;
                        b_reg <= tail_reg;
                    end else begin
                        a_reg <= s_next_link;
                        b_reg <= s_prev_link;
                    end
                end
            end
            S_LOOKUP: begin
                // insert keeps the target as the near neighbor
                a_reg <= (op_reg == OP_INS_BEFORE) ? id_reg : l_rd_next;
                b_reg <= (op_reg == OP_INS_AFTER) ? id_reg : l_rd_prev;
            end
            default: begin
                a_reg <= a_reg;
            end
        endcase

        // result register
        if (out_load) begin
            m_out_head <= head_reg;
            m_out_tail <= tail_reg;
            m_status   <= status_reg;
            case (op_reg)
                OP_NONE: begin
                    m_out_value <= '0;
                    m_out_index <= NIL;
                    m_out_next  <= NIL;
                    m_out_prev  <= NIL;
                end
                OP_READ, OP_DELETE: begin
                    m_out_value <= v_rd_data;
                    m_out_index <= id_reg;
                    m_out_next  <= a_reg;
                    m_out_prev  <= b_reg;
                end
                default: begin
                    m_out_value <= val_reg;
                    m_out_index <= n_link;
                    m_out_next  <= a_reg;
                    m_out_prev  <= b_reg;
                end
            endcase
        end
    end

    ldl_value_mem #(
        .NODES (NODES)
    ) u_value_mem (
        .aclk    (aclk),
        .rd_en   (v_rd_en),
        .wr_en   (v_wr_en),
        .addr    (v_addr),
        .wr_data (val_reg),
        .rd_data (v_rd_data)
    );

    ldl_link_mem #(
        .NODES (NODES)
    ) u_link_mem (
        .aclk    (aclk),
        .rd_en   (l_rd_en),
        .wr_en   (l_wr_en),
        .addr    (l_addr),
        .wr_next (l_wr_next),
        .wr_prev (l_wr_prev),
        .rd_next (l_rd_next),
        .rd_prev (l_rd_prev)
    );

    // allocator never runs past the store
    a_alloc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        alloc_reg <= CNTW'(NODES))
        else $error("allocator beyond store depth");

    // link RAM is written only in the link and node update steps
    a_link_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_LOOKUP || state_reg == S_DONE)
        |-> !(l_wr_en.nxt || l_wr_en.prv))
        else $error("link write outside update steps");

    // a full-store result only when the allocator is exhausted
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_status != ST_FULL || alloc_reg == CNTW'(NODES)))
        else $error("full status with free slots");

    // a new result appears only out of the done step
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside done step");

endmodule

FILE: test/ldl_list_checker.sv
// ============================================================================
// ldl_list_checker - result checker of the indexed doubly linked list unit
// Watches both channels. Every accepted request updates a private copy of the
// node stores, head, tail and allocator, and the node report it should give
// is queued. Every accepted result is compared field by field with the oldest
// queued report. Failures and open reports are handed to the testbench top.
// ============================================================================
module ldl_list_checker
    import ldl_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic [REQ_W-1:0]            s_req_type,
    input  logic signed [LINK_W-1:0]    s_node_index,
    input  logic signed [VALUE_W-1:0]   s_value,
    input  logic signed [LINK_W-1:0]    s_next_link,
    input  logic signed [LINK_W-1:0]    s_prev_link,
    input  logic signed [LINK_W-1:0]    s_head_link,
    input  logic signed [LINK_W-1:0]    s_tail_link,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [VALUE_W-1:0]   m_out_value,
    input  logic signed [LINK_W-1:0]    m_out_index,
    input  logic signed [LINK_W-1:0]    m_out_next,
    input  logic signed [LINK_W-1:0]    m_out_prev,
    input  logic signed [LINK_W-1:0]    m_out_head,
    input  logic signed [LINK_W-1:0]    m_out_tail,
    input  logic [STATUS_W-1:0]         m_status,
    output int                          n_fail,
    output int                          n_open
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NO_LINK = -1;

    // one result item: the addressed node and the list ends after the request
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic signed [LINK_W-1:0]  index;
        logic signed [LINK_W-1:0]  nxt;
        logic signed [LINK_W-1:0]  prv;
        logic signed [LINK_W-1:0]  head;
        logic signed [LINK_W-1:0]  tail;
        status_t                   status;
    } node_report_t;

    // private copy of the list state
    logic signed [VALUE_W-1:0] val_mem [NODES];
    logic signed [LINK_W-1:0]  nxt_mem [NODES];
    logic signed [LINK_W-1:0]  prv_mem [NODES];
    int lst_head;
    int lst_tail;
    int lst_alloc;

    node_report_t node_reports_q [$];
    int fails;

    initial begin
        fails  = 0;
        n_fail = 0;
        n_open = 0;
    end

    function automatic bit in_range(input int i);
        return i >= 0 && i < NODES;
    endfunction

    // apply one request to the list copy, return the node report it gives
    function automatic node_report_t apply_list_request(
        input logic [REQ_W-1:0] req,
        input int               id,
        input int               val,
        input int               nl,
        input int               pl,
        input int               hl,
        input int               tl
    );
        node_report_t rep;
        int n, p, nx, t, nn, np;
        rep.value  = '0;
        rep.index  = LINK_W'(NO_LINK);
        rep.nxt    = LINK_W'(NO_LINK);
        rep.prv    = LINK_W'(NO_LINK);
        rep.status = ST_OK;
        case (req)
            REQ_BEGIN: begin
                lst_head  = hl;
                lst_tail  = tl;
                lst_alloc = 0;
            end
            REQ_LOAD: begin
                if (lst_alloc >= NODES) begin
                    rep.status = ST_FULL;
                end else begin
                    n = lst_alloc;
                    lst_alloc++;
                    val_mem[n] = val;
                    nxt_mem[n] = nl;
                    prv_mem[n] = pl;
                    rep.value  = val;
                    rep.index  = LINK_W'(n);
                    rep.nxt    = LINK_W'(nl);
                    rep.prv    = LINK_W'(pl);
                end
            end
            REQ_DELETE, REQ_READ: begin
                if (!in_range(id)) begin
                    rep.status = ST_RANGE;
                end else begin
                    p  = prv_mem[id];
                    nx = nxt_mem[id];
                    // unlink: dangling neighbors are skipped
                    if (req == REQ_DELETE) begin
                        if (p == NO_LINK) lst_head = nx;
                        else if (in_range(p)) nxt_mem[p] = nx;
                        if (nx == NO_LINK) lst_tail = p;
                        else if (in_range(nx)) prv_mem[nx] = p;
                    end
                    rep.value = val_mem[id];
                    rep.index = LINK_W'(id);
                    rep.nxt   = LINK_W'(nx);
                    rep.prv   = LINK_W'(p);
                end
            end
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
                if (id != NO_LINK && !in_range(id)) begin
                    rep.status = ST_RANGE;
                end else if (lst_alloc >= NODES) begin
                    rep.status = ST_FULL;
                end else begin
                    n = lst_alloc;
                    lst_alloc++;
                    if (id == NO_LINK && lst_head == NO_LINK && lst_tail == NO_LINK) begin
                        // empty list: new node is both ends
                        nn = NO_LINK;
                        np = NO_LINK;
                        lst_head = n;
                        lst_tail = n;
                    end else if (id == NO_LINK && req == REQ_INS_AFTER) begin
                        // new head
                        nn = lst_head;
                        np = NO_LINK;
                        if (in_range(lst_head)) prv_mem[lst_head] = n;
                        if (lst_head == NO_LINK) lst_tail = n;
                        lst_head = n;
                    end else if (id == NO_LINK) begin
                        // new tail
                        np = lst_tail;
                        nn = NO_LINK;
                        if (in_range(lst_tail)) nxt_mem[lst_tail] = n;
                        if (lst_tail == NO_LINK) lst_head = n;
                        lst_tail = n;
                    end else if (req == REQ_INS_AFTER) begin
                        t = nxt_mem[id];
                        if (t == NO_LINK) lst_tail = n;
                        else if (in_range(t)) prv_mem[t] = n;
                        nxt_mem[id] = n;
                        nn = t;
                        np = id;
                    end else begin
                        t = prv_mem[id];
                        if (t == NO_LINK) lst_head = n;
                        else if (in_range(t)) nxt_mem[t] = n;
                        prv_mem[id] = n;
                        np = t;
                        nn = id;
                    end
                    val_mem[n] = val;
                    nxt_mem[n] = nn;
                    prv_mem[n] = np;
                    rep.value  = val;
                    rep.index  = LINK_W'(n);
                    rep.nxt    = LINK_W'(nn);
                    rep.prv    = LINK_W'(np);
                end
            end
            default: ;  // unknown request: no change
        endcase
        rep.head = LINK_W'(lst_head);
        rep.tail = LINK_W'(lst_tail);
        return rep;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // predict on accepted requests, compare on accepted results
    always @(posedge aclk) begin : watch
        node_report_t want;
        if (!aresetn) begin
            lst_head  = NO_LINK;
            lst_tail  = NO_LINK;
            lst_alloc = 0;
            node_reports_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                node_reports_q.push_back(apply_list_request(s_req_type,
                    int'(s_node_index), int'(s_value), int'(s_next_link),
                    int'(s_prev_link), int'(s_head_link), int'(s_tail_link)));
            end
            if (m_valid && m_ready) begin
                if (node_reports_q.size() == 0) begin
                    $error("result item with no request waiting for it");
                    fails++;
                end else begin
                    want = node_reports_q.pop_front();
                    check_field("out_value", int'(want.value), int'(m_out_value));
                    check_field("out_index", int'(want.index), int'(m_out_index));
                    check_field("out_next", int'(want.nxt), int'(m_out_next));
                    check_field("out_prev", int'(want.prv), int'(m_out_prev));
                    check_field("out_head", int'(want.head), int'(m_out_head));
                    check_field("out_tail", int'(want.tail), int'(m_out_tail));
                    check_field("status", int'(want.status), int'(m_status));
                end
            end
        end
        n_open <= node_reports_q.size();
        n_fail <= fails;
    end

endmodule

FILE: test/tb_indexed_doubly_linked_list_unit.sv
// ============================================================================
// tb_indexed_doubly_linked_list_unit - testbench of the linked list unit
// Directed items cover bad indexes, unknown requests, inserts into an empty
// list and at both list edges, deletes and dangling links. Random sessions
// then build lists by inserts or by loads and work on them, mixed with
// noise items, one fill up to a full store and drain pauses. Both channels
// idle at random; the checker module predicts and compares results.
// ============================================================================
module tb_indexed_doubly_linked_list_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import ldl_pkg::*;

    localparam int NODES        = NODES_DEF;
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 550;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NO_LINK      = -1;

    // request codes the block does not know
    localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [REQ_W-1:0]           s_req_type;
    logic signed [LINK_W-1:0]   s_node_index;
    logic signed [VALUE_W-1:0]  s_value;
    logic signed [LINK_W-1:0]   s_next_link;
    logic signed [LINK_W-1:0]   s_prev_link;
    logic signed [LINK_W-1:0]   s_head_link;
    logic signed [LINK_W-1:0]   s_tail_link;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [VALUE_W-1:0]  m_out_value;
    logic signed [LINK_W-1:0]   m_out_index;
    logic signed [LINK_W-1:0]   m_out_next;
    logic signed [LINK_W-1:0]   m_out_prev;
    logic signed [LINK_W-1:0]   m_out_head;
    logic signed [LINK_W-1:0]   m_out_tail;
    logic [STATUS_W-1:0]        m_status;

    int n_fail;
    int n_open;
    int cycle_cnt;

    // stimulus bookkeeping: allocator, slots ever written whole, live nodes
    int alloc_n;
    bit written [NODES];
    int written_ids [$];
    int live_ids [$];
    int stim_count;
    bit calm;

    indexed_doubly_linked_list_unit #(.NODES(NODES)) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_node_index (s_node_index),
        .s_value      (s_value),
        .s_next_link  (s_next_link),
        .s_prev_link  (s_prev_link),
        .s_head_link  (s_head_link),
        .s_tail_link  (s_tail_link),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_index  (m_out_index),
        .m_out_next   (m_out_next),
        .m_out_prev   (m_out_prev),
        .m_out_head   (m_out_head),
        .m_out_tail   (m_out_tail),
        .m_status     (m_status)
    );

    ldl_list_checker #(.NODES(NODES)) u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_node_index (s_node_index),
        .s_value      (s_value),
        .s_next_link  (s_next_link),
        .s_prev_link  (s_prev_link),
        .s_head_link  (s_head_link),
        .s_tail_link  (s_tail_link),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_value  (m_out_value),
        .m_out_index  (m_out_index),
        .m_out_next   (m_out_next),
        .m_out_prev   (m_out_prev),
        .m_out_head   (m_out_head),
        .m_out_tail   (m_out_tail),
        .m_status     (m_status),
        .n_fail       (n_fail),
        .n_open       (n_open)
    );

    // clock
    initial aclk = 1'b0;
    always #CLK_HALF aclk = ~aclk;

    // result side stalls, none while calm
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 19);
    end

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("[indexed_doubly_linked_list_unit] ERROR");
            $finish;
        end
    end

    function automatic int rnd_link();
        return int'($urandom_range(2047)) - 1024;
    endfunction

    // negative index other than -1
    function automatic int bad_index();
        return -2 - int'($urandom_range(1022));
    endfunction

    function automatic int pick_written();
        if (written_ids.size() == 0) return NO_LINK;
        return written_ids[$urandom_range(written_ids.size() - 1)];
    endfunction

    // live node, else a list end for inserts or any written node otherwise
    function automatic int pick_live(input bit for_insert);
        if (live_ids.size() != 0) return live_ids[$urandom_range(live_ids.size() - 1)];
        return for_insert ? NO_LINK : pick_written();
    endfunction

    function automatic int claim_slot();
        int n;
        n = alloc_n;
        alloc_n++;
        if (!written[n]) begin
            written[n] = 1'b1;
            written_ids.push_back(n);
        end
        return n;
    endfunction

    // drive one request item and wait until it is accepted
    task automatic push_request(
        input logic [REQ_W-1:0]   req,
        input int                 idx,
        input logic [VALUE_W-1:0] val,
        input int                 nl,
        input int                 pl,
        input int                 hl,
        input int                 tl
    );
        int k;
        while (!calm && $urandom_range(99) < 19) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_node_index <= LINK_W'(idx);
        s_value      <= val;
        s_next_link  <= LINK_W'(nl);
        s_prev_link  <= LINK_W'(pl);
        s_head_link  <= LINK_W'(hl);
        s_tail_link  <= LINK_W'(tl);
        do @(posedge aclk); while (!s_ready);
        stim_count++;
        case (req)
            REQ_BEGIN: begin
                alloc_n = 0;
                live_ids.delete();
            end
            REQ_LOAD: begin
                if (alloc_n < NODES) void'(claim_slot());
            end
            REQ_DELETE: begin
                for (k = 0; k < live_ids.size(); k++) begin
                    if (live_ids[k] == idx) begin
                        live_ids.delete(k);
                        break;
                    end
                end
            end
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
                if ((idx == NO_LINK || (idx >= 0 && idx < NODES)) && alloc_n < NODES)
                    live_ids.push_back(claim_slot());
            end
            default: ;
        endcase
    endtask

    // stop sending until every result has come back
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (n_open != 0) @(posedge aclk);
    endtask

    // any request code, target written, -1 or out of range, random fields
    task automatic push_noise();
        int r;
        int idx;
        r = $urandom_range(2);
        idx = (r == 0) ? pick_written() : (r == 1) ? NO_LINK : bad_index();
        push_request(REQ_W'($urandom_range(7)), idx, $urandom, rnd_link(), rnd_link(),
                     rnd_link(), rnd_link());
    endtask

    // mostly well-formed operations on the current list
    task automatic run_list_ops(input int n_ops);
        int i;
        int r;
        for (i = 0; i < n_ops; i++) begin
            r = $urandom_range(99);
            if (r < 30) begin
                push_request((r < 15) ? REQ_INS_AFTER : REQ_INS_BEFORE, NO_LINK, $urandom,
                             rnd_link(), rnd_link(), rnd_link(), rnd_link());
            end else if (r < 50) begin
                push_request((r < 40) ? REQ_INS_AFTER : REQ_INS_BEFORE, pick_live(1'b1),
                             $urandom, rnd_link(), rnd_link(), rnd_link(), rnd_link());
            end else if (r < 68) begin
                push_request(REQ_DELETE, pick_live(1'b0), $urandom, rnd_link(), rnd_link(),
                             rnd_link(), rnd_link());
            end else if (r < 84) begin
                push_request(REQ_READ, ($urandom_range(3) == 0) ? pick_written() :
                             pick_live(1'b0), $urandom, rnd_link(), rnd_link(),
                             rnd_link(), rnd_link());
            end else if (r < 88) begin
                push_request((r < 86) ? REQ_DELETE : REQ_READ,
                             $urandom_range(1) ? NO_LINK : bad_index(), $urandom,
                             rnd_link(), rnd_link(), rnd_link(), rnd_link());
            end else if (r < 92) begin
                push_request((r < 90) ? REQ_INS_AFTER : REQ_INS_BEFORE, bad_index(),
                             $urandom, rnd_link(), rnd_link(), rnd_link(), rnd_link());
            end else begin
                push_noise();
            end
        end
    endtask

    // load a consistent list 0..k-1 after a begin, then work on it
    task automatic run_loaded_list();
        int k;
        int i;
        k = $urandom_range(1, 12);
        push_request(REQ_BEGIN, NO_LINK, $urandom, rnd_link(), rnd_link(), 0, k - 1);
        for (i = 0; i < k; i++) begin
            push_request(REQ_LOAD, NO_LINK, $urandom, (i == k - 1) ? NO_LINK : i + 1,
                         (i == 0) ? NO_LINK : i - 1, rnd_link(), rnd_link());
        end
        for (i = 0; i < k; i++) live_ids.push_back(i);
        run_list_ops($urandom_range(5, 25));
    endtask

    // fill the store until full, then hit the full store
    task automatic fill_store();
        while (alloc_n < NODES) begin
            push_request(REQ_LOAD, NO_LINK, $urandom, rnd_link(), rnd_link(),
                         rnd_link(), rnd_link());
        end
        push_request(REQ_LOAD, NO_LINK, $urandom, rnd_link(), rnd_link(), NO_LINK, NO_LINK);
        push_request(REQ_INS_AFTER, NO_LINK, $urandom, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_BEFORE, pick_written(), $urandom, NO_LINK, NO_LINK,
                     NO_LINK, NO_LINK);
        // index check comes before the full check
        push_request(REQ_INS_AFTER, bad_index(), $urandom, NO_LINK, NO_LINK,
                     NO_LINK, NO_LINK);
        push_request(REQ_READ, pick_written(), $urandom, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
    endtask

    initial begin : stimulus
        int rand_goal;
        int rand_start;
        int fill_start;
        bit filled;
        int r;

        alloc_n    = 0;
        stim_count = 0;
        calm       = 1'b0;
        filled     = 1'b0;
        cycle_cnt    <= 0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_BEGIN;
        s_node_index <= '0;
        s_value      <= '0;
        s_next_link  <= '0;
        s_prev_link  <= '0;
        s_head_link  <= '0;
        s_tail_link  <= '0;
        m_ready      <= 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: bad indexes and unknown requests
        push_request(REQ_READ, NO_LINK, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_DELETE, -1024, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_AFTER, -2, 1, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_RSVD_A, 1023, '1, 1023, -1024, 1023, -1024);
        push_request(REQ_RSVD_B, -1024, 32'h5A5A_A5A5, -1024, 1023, -1024, 1023);
        // directed: empty list, both edges, middle, reads and deletes
        push_request(REQ_INS_BEFORE, NO_LINK, 10, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_AFTER, NO_LINK, 11, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_BEFORE, NO_LINK, 12, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_AFTER, 2, 13, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_BEFORE, 1, 14, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_AFTER, 0, 15, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_BEFORE, 0, 16, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_READ, 4, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_DELETE, 0, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_DELETE, 4, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_DELETE, 3, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_READ, 5, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        // directed: extreme begin links, extreme values, dangling links
        push_request(REQ_BEGIN, NO_LINK, 0, NO_LINK, NO_LINK, 1023, -1024);
        push_request(REQ_LOAD, NO_LINK, 32'h7FFF_FFFF, 1023, -1024, NO_LINK, NO_LINK);
        push_request(REQ_LOAD, NO_LINK, 32'h8000_0000, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_AFTER, NO_LINK, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_DELETE, 0, 0, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        push_request(REQ_INS_BEFORE, 1, '1, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        // directed: head missing, tail present
        push_request(REQ_BEGIN, NO_LINK, 0, NO_LINK, NO_LINK, NO_LINK, 1);
        push_request(REQ_INS_BEFORE, NO_LINK, 17, NO_LINK, NO_LINK, NO_LINK, NO_LINK);
        hold_until_drained();

        // random sessions
        rand_start = stim_count;
        rand_goal  = stim_count + RANDOM_ITEMS;
        while (stim_count < rand_goal) begin
            calm = (stim_count >= rand_start + 300) && (stim_count < rand_start + 400);
            if (!filled && stim_count >= rand_start + 150) begin
                fill_start = stim_count;
                fill_store();
                rand_goal += stim_count - fill_start;
                filled = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 45) begin
                push_request(REQ_BEGIN, NO_LINK, $urandom, rnd_link(), rnd_link(),
                             NO_LINK, NO_LINK);
                run_list_ops($urandom_range(8, 30));
            end else if (r < 75) begin
                run_loaded_list();
            end else begin
                repeat ($urandom_range(3, 10)) push_noise();
            end
            if ($urandom_range(3) == 0) hold_until_drained();
        end
        calm = 1'b0;

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (n_fail == 0 && n_open == 0) begin
            $display("[indexed_doubly_linked_list_unit] OK");
        end else begin
            $display("[indexed_doubly_linked_list_unit] ERROR");
        end
        $finish;
    end

endmodule
